// ----- hw/rtl/hsv_to_rgb_converter_assert.svh -----
// Assertion macros for the colour conversion block.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define HSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define HSV_ASSERT_NEVER(lbl, cond, msg) \
  `HSV_ASSERT(lbl, !(cond), msg)

`endif

// ----- hw/rtl/hsv2rgb_pkg.sv -----
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Internal channel resolution; full scale stands for 1.0.
  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned CB           = CHANNEL_BITS;
  localparam logic [CB-1:0] FULL_SCALE = CB'((64'd1 << CB) - 64'd1);

  // Sector width in degrees; levels run 0 to LVL_MAX.
  localparam int unsigned LVL_W     = 6;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(60);

  localparam logic [8:0] HUE_60  = 9'd60;
  localparam logic [8:0] HUE_120 = 9'd120;
  localparam logic [8:0] HUE_180 = 9'd180;
  localparam logic [8:0] HUE_240 = 9'd240;
  localparam logic [8:0] HUE_300 = 9'd300;
  localparam logic [8:0] HUE_360 = 9'd360;
  localparam logic [8:0] HUE_480 = 9'd480;

  // Common denominator of the conversion and derived widths.
  localparam int unsigned DEN      = 60 * ((1 << CB) - 1);
  localparam int unsigned TERM_W   = $clog2(DEN + 1);
  localparam int unsigned NUM_W    = CB + TERM_W;
  localparam int unsigned RECIP_SH = NUM_W + TERM_W;
  localparam int unsigned RECIP_W  = NUM_W + 1;
  localparam int unsigned PROD_W   = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / DEN);

  localparam int unsigned NUM_CH = 3;

  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [TERM_W-1:0] term_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [CB-1:0]     chan_t;

endpackage

// ----- hw/rtl/hsv_to_rgb_converter.sv -----
`timescale 1ns / 1ps

// HSV to RGB colour converter for a pixel stream.
// The input channel carries hue (whole degrees), saturation and brightness;
// a transaction completes on a rising edge with in_valid_i high and
// in_stall_o low. The output channel carries red, green and blue; a
// transaction completes when out_valid_o is high and out_stall_i is low.
// The datapath is a five stage pipeline: sector decode, chroma term,
// brightness product, reciprocal multiply for the division by 60 times full
// scale, and a one-step quotient correction that feeds the output register.
// One pixel is accepted every cycle while the pipeline is not stalled;
// the rate is set by the single pipeline enable.
// Each channel is truncated exactly as floor(V*(60F - S*(60-k))/(60F)).
// Reset empties the pipeline by clearing all stage valid bits; data
// registers are not reset. While a valid result is stalled by the
// receiver, the whole pipeline holds and in_stall_o is raised, so nothing
// is lost or repeated. Bubbles flow on freely when no result is waiting.
// Hue values from 360 upward are treated as the last sector.
module hsv_to_rgb_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [8:0] hue_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] brightness_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);
  import hsv2rgb_pkg::*;

  // Stage valid bits; index 4 is the output register.
  logic [4:0] vld_q, vld_d;
  logic       en;

  // The pipeline moves only when the output register is free or taken.
  assign en         = !(vld_q[4] && out_stall_i);
  assign in_stall_o = !en;

  assign vld_d = {vld_q[3:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: clamp the fractions, reduce the hue and pick the levels.
  chan_t            s_sat, v_sat;
  logic [8:0]       h_red;
  logic [6:0]       r120;
  logic [6:0]       hue_dist;
  lvl_t             t_lvl;
  lvl_t [NUM_CH-1:0] k_d;

  always_comb begin
    s_sat = ({24'd0, saturation_i} > 32'(FULL_SCALE)) ? FULL_SCALE : CB'(saturation_i);
    v_sat = ({24'd0, brightness_i} > 32'(FULL_SCALE)) ? FULL_SCALE : CB'(brightness_i);

    // Hue modulo 120 by selecting one subtraction.
    if (hue_i >= HUE_480) begin
      h_red = hue_i - HUE_480;
    end else if (hue_i >= HUE_360) begin
      h_red = hue_i - HUE_360;
    end else if (hue_i >= HUE_240) begin
      h_red = hue_i - HUE_240;
    end else if (hue_i >= HUE_120) begin
      h_red = hue_i - HUE_120;
    end else begin
      h_red = hue_i;
    end
    r120     = h_red[6:0];
    hue_dist = (r120 >= 7'(HUE_60)) ? (r120 - 7'(HUE_60)) : (7'(HUE_60) - r120);
    t_lvl    = LVL_MAX - hue_dist[LVL_W-1:0];

    // Levels listed as blue, green, red; index 0 is red, 1 green, 2 blue.
    if (hue_i < HUE_60) begin
      k_d = {lvl_t'(0), t_lvl, LVL_MAX};
    end else if (hue_i < HUE_120) begin
      k_d = {lvl_t'(0), LVL_MAX, t_lvl};
    end else if (hue_i < HUE_180) begin
      k_d = {t_lvl, LVL_MAX, lvl_t'(0)};
    end else if (hue_i < HUE_240) begin
      k_d = {LVL_MAX, t_lvl, lvl_t'(0)};
    end else if (hue_i < HUE_300) begin
      k_d = {LVL_MAX, lvl_t'(0), t_lvl};
    end else begin
      k_d = {t_lvl, lvl_t'(0), LVL_MAX};
    end
  end

  chan_t             s1_s_q, s1_v_q;
  lvl_t [NUM_CH-1:0] s1_k_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_s_q <= s_sat;
      s1_v_q <= v_sat;
      s1_k_q <= k_d;
    end
  end

  // Stage 2: term = 60F - S*(60-k) per channel.
  term_t [NUM_CH-1:0] term_d, s2_term_q;
  chan_t              s2_v_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      term_d[c] = term_t'(DEN) -
                  (term_t'(s1_s_q) * term_t'(LVL_MAX - s1_k_q[c]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_term_q <= term_d;
      s2_v_q    <= s1_v_q;
    end
  end

  // Stage 3: numerator = V * term.
  num_t [NUM_CH-1:0] num_d, s3_num_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      num_d[c] = num_t'(s2_v_q) * num_t'(s2_term_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_num_q <= num_d;
    end
  end

  // Stage 4: quotient estimate by reciprocal; low by at most one.
  logic [NUM_CH-1:0][PROD_W-1:0] prod;
  chan_t [NUM_CH-1:0]            q0_d, s4_q0_q;
  num_t  [NUM_CH-1:0]            s4_num_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = PROD_W'(s3_num_q[c]) * PROD_W'(RECIP);
      q0_d[c] = prod[c][RECIP_SH +: CB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q0_q  <= q0_d;
      s4_num_q <= s3_num_q;
    end
  end

  // Stage 5: bump the estimate when the remainder reaches the divisor.
  num_t  [NUM_CH-1:0] rem;
  chan_t [NUM_CH-1:0] q_d, out_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rem[c] = s4_num_q[c] - (num_t'(s4_q0_q[c]) * num_t'(DEN));
      q_d[c] = s4_q0_q[c] + CB'(rem[c] >= num_t'(DEN));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= q_d;
    end
  end

  assign out_valid_o = vld_q[4];
  assign red_o       = 8'(out_q[0]);
  assign green_o     = 8'(out_q[1]);
  assign blue_o      = 8'(out_q[2]);

`include "hsv_to_rgb_converter_assert.svh"

  // A stalled result holds its place and its value.
  `HSV_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(red_o) && $stable(green_o) && $stable(blue_o)), "stalled result changed")
  // Valid bits advance exactly one stage whenever the pipeline moves.
  `HSV_ASSERT(a_vld_shift, en |=> (vld_q[4:1] == $past(vld_q[3:0])), "valid bit lost or duplicated")
  // The input side is stalled only behind a waiting result.
  `HSV_ASSERT_NEVER(a_stall_cause, in_stall_o && !(out_valid_o && out_stall_i), "spurious input stall")
  // A result never exceeds full scale.
  `HSV_ASSERT_NEVER(a_range, out_valid_o && ((out_q[0] > FULL_SCALE) || (out_q[1] > FULL_SCALE) || (out_q[2] > FULL_SCALE)), "channel above full scale")

endmodule
